@@ rtl/cpi_pkg.sv @@
// ----------------------------------------------------------------------------
// cpi_pkg
// Shared constants, the pipeline item record and helpers for the circle pair
// intersection datapath.
// ----------------------------------------------------------------------------
package cpi_pkg;

    localparam int SQRT_STEPS = 32;   // one root bit per stage, 64-bit radicand
    localparam int DIV_STEPS  = 32;   // one quotient bit per stage

    // five front stages, two mid stages, three chord stages,
    // one product stage, two sum stages, output register
    localparam int PIPE_DEPTH = 14 + 2 * SQRT_STEPS + 2 * DIV_STEPS;

    localparam logic signed [35:0] S32_MAX_W = 36'sd2147483647;
    localparam logic signed [35:0] S32_MIN_W = -36'sd2147483648;

    typedef struct packed {
        logic [31:0] c0x;
        logic [31:0] c0y;
        logic [30:0] r0;
        logic [30:0] r1;
        logic [32:0] dx;
        logic [32:0] dy;
        logic [31:0] s;
        logic [30:0] df;
        logic [32:0] adx;
        logic [32:0] ady;
        logic        far;
        logic [63:0] dxsq;
        logic [63:0] dysq;
        logic [63:0] ssq;
        logic [61:0] dfsq;
        logic [61:0] r0sq;
        logic [61:0] r1sq;
        logic [64:0] d2;
        logic [62:0] rdiff;
        logic        ok;
        logic [66:0] num;
        logic [31:0] d;
        logic        nneg;
        logic [63:0] nmag;
        logic        ovf;
        logic [30:0] amag;
        logic [61:0] amsq;
        logic [61:0] hsq;
        logic [30:0] h;
        logic [63:0] pax;
        logic [63:0] pay;
        logic [63:0] phx;
        logic [63:0] phy;
        logic [35:0] px;
        logic [35:0] py;
        logic [35:0] ox;
        logic [35:0] oy;
        logic [35:0] fx;
        logic [35:0] fy;
        logic [35:0] sx;
        logic [35:0] sy;
    } item_t;

    function automatic logic [31:0] sat32(input logic [35:0] v);
        logic [31:0] r;
        if ($signed(v) > S32_MAX_W)
            r = 32'h7FFF_FFFF;
        else if ($signed(v) < S32_MIN_W)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ rtl/cpi_sqrt.sv @@
// ----------------------------------------------------------------------------
// cpi_sqrt
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module cpi_sqrt
    import cpi_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] v,
    output logic [31:0] root
);

    logic [63:0] v_reg    [SQRT_STEPS];
    logic [33:0] rem_reg  [SQRT_STEPS];
    logic [31:0] root_reg [SQRT_STEPS];
    logic [63:0] v_next    [SQRT_STEPS];
    logic [33:0] rem_next  [SQRT_STEPS];
    logic [31:0] root_next [SQRT_STEPS];
    logic [63:0] v_p    [SQRT_STEPS];
    logic [33:0] rem_p  [SQRT_STEPS];
    logic [31:0] root_p [SQRT_STEPS];
    logic [35:0] t      [SQRT_STEPS];
    logic [35:0] trial  [SQRT_STEPS];

    always_comb
    begin
        for (int i = 0; i < SQRT_STEPS; i++)
        begin
            if (i == 0)
            begin
                v_p[i]    = v;
                rem_p[i]  = '0;
                root_p[i] = '0;
            end
            else
            begin
                v_p[i]    = v_reg[i-1];
                rem_p[i]  = rem_reg[i-1];
                root_p[i] = root_reg[i-1];
            end
            t[i]     = {rem_p[i], v_p[i][63:62]};
            trial[i] = {2'b00, root_p[i], 2'b01};
            if (t[i] >= trial[i])
            begin
                rem_next[i]  = 34'(t[i] - trial[i]);
                root_next[i] = {root_p[i][30:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = t[i][33:0];
                root_next[i] = {root_p[i][30:0], 1'b0};
            end
            v_next[i] = {v_p[i][61:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < SQRT_STEPS; i++)
            begin
                v_reg[i]    <= v_next[i];
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
            end
        end
    end

    assign root = root_reg[SQRT_STEPS-1];

endmodule

@@ rtl/cpi_div.sv @@
// ----------------------------------------------------------------------------
// cpi_div
// Pipelined restoring divider, one quotient bit per stage. Gives the low 32
// quotient bits of n / dv; exact when n[63:32] < dv.
// ----------------------------------------------------------------------------
module cpi_div
    import cpi_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] n,
    input  logic [33:0] dv,
    output logic [31:0] q
);

    logic [34:0] rem_reg [DIV_STEPS];
    logic [31:0] lo_reg  [DIV_STEPS];
    logic [31:0] q_reg   [DIV_STEPS];
    logic [33:0] dv_reg  [DIV_STEPS];
    logic [34:0] rem_next [DIV_STEPS];
    logic [31:0] lo_next  [DIV_STEPS];
    logic [31:0] q_next   [DIV_STEPS];
    logic [34:0] rem_p [DIV_STEPS];
    logic [31:0] lo_p  [DIV_STEPS];
    logic [31:0] q_p   [DIV_STEPS];
    logic [33:0] dv_p  [DIV_STEPS];
    logic [34:0] t     [DIV_STEPS];

    always_comb
    begin
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            if (i == 0)
            begin
                rem_p[i] = {3'b000, n[63:32]};
                lo_p[i]  = n[31:0];
                q_p[i]   = '0;
                dv_p[i]  = dv;
            end
            else
            begin
                rem_p[i] = rem_reg[i-1];
                lo_p[i]  = lo_reg[i-1];
                q_p[i]   = q_reg[i-1];
                dv_p[i]  = dv_reg[i-1];
            end
            t[i] = {rem_p[i][33:0], lo_p[i][31]};
            if (t[i] >= {1'b0, dv_p[i]})
            begin
                rem_next[i] = t[i] - {1'b0, dv_p[i]};
                q_next[i]   = {q_p[i][30:0], 1'b1};
            end
            else
            begin
                rem_next[i] = t[i];
                q_next[i]   = {q_p[i][30:0], 1'b0};
            end
            lo_next[i] = {lo_p[i][30:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                rem_reg[i] <= rem_next[i];
                lo_reg[i]  <= lo_next[i];
                q_reg[i]   <= q_next[i];
                dv_reg[i]  <= dv_p[i];
            end
        end
    end

    assign q = q_reg[DIV_STEPS-1];

endmodule

@@ rtl/circle_pair_intersection.sv @@
// PIPE_DEPTH = 142 register stages lie between an accepted request and its result on the
//   master side: two square-root chains and two divider chains of 32 stages each, set by
//   one root or quotient bit per stage, plus 14 scalar stages.
// Throughput: one request per cycle; a stall on the master side freezes every stage.
// Reset clears the valid bits only; the datapath registers hold no reset value.
// ----------------------------------------------------------------------------
// circle_pair_intersection
// Intersection points of two plane circles, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
module circle_pair_intersection
    import cpi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // center0_x, center0_y, radius0, center1_x, center1_y, radius1, 2 pad bits
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // first_x, first_y, second_x, second_y
    output logic [127:0] m_tdata,
    // found
    output logic         m_tuser
);

    logic                  adv;
    logic [PIPE_DEPTH-2:0] valid_reg;

    item_t a_next, a_reg, b_next, b_reg, c_next, c_reg, d_next, d_reg;
    item_t e_next, e_reg, f_next, f_reg, g_next, g_reg;
    item_t h_next, h_reg, i_next, i_reg, j_next, j_reg, k_next, k_reg;
    item_t m_next, m_reg, n_next, n_reg;
    item_t sq1_line [SQRT_STEPS];
    item_t dv1_line [DIV_STEPS];
    item_t sq2_line [SQRT_STEPS];
    item_t dv2_line [DIV_STEPS];

    logic [31:0]  root1, root2, q_a, q_ax, q_ay, q_hx, q_hy;
    logic [127:0] data_next, data_reg;
    logic         found_next, found_reg;
    logic         out_valid_reg;

    logic [31:0] in_c0x, in_c0y, in_c1x, in_c1y;
    logic [30:0] in_r0, in_r1;
    logic [66:0] neg_num;

    // advance the whole pipe unless a finished result is held
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = found_reg;

    assign in_c0x = s_tdata[31:0];
    assign in_c0y = s_tdata[63:32];
    assign in_r0  = s_tdata[94:64];
    assign in_c1x = s_tdata[126:95];
    assign in_c1y = s_tdata[158:127];
    assign in_r1  = s_tdata[189:159];

    // front: center offset, radius sum and difference
    always_comb
    begin
        a_next     = 'x;
        a_next.c0x = in_c0x;
        a_next.c0y = in_c0y;
        a_next.r0  = in_r0;
        a_next.r1  = in_r1;
        a_next.dx  = 33'($signed(in_c1x)) - 33'($signed(in_c0x));
        a_next.dy  = 33'($signed(in_c1y)) - 33'($signed(in_c0y));
        a_next.s   = {1'b0, in_r0} + {1'b0, in_r1};
        a_next.df  = (in_r0 >= in_r1) ? in_r0 - in_r1 : in_r1 - in_r0;
    end

    // magnitudes and the coarse too-far test
    always_comb
    begin
        b_next     = a_reg;
        b_next.adx = a_reg.dx[32] ? 33'(-a_reg.dx) : a_reg.dx;
        b_next.ady = a_reg.dy[32] ? 33'(-a_reg.dy) : a_reg.dy;
        b_next.far = (b_next.adx > {1'b0, a_reg.s}) || (b_next.ady > {1'b0, a_reg.s});
    end

    // squares, one multiplier each
    always_comb
    begin
        c_next      = b_reg;
        c_next.dxsq = b_reg.adx[31:0] * b_reg.adx[31:0];
        c_next.dysq = b_reg.ady[31:0] * b_reg.ady[31:0];
        c_next.ssq  = b_reg.s * b_reg.s;
        c_next.dfsq = b_reg.df * b_reg.df;
        c_next.r0sq = b_reg.r0 * b_reg.r0;
        c_next.r1sq = b_reg.r1 * b_reg.r1;
    end

    always_comb
    begin
        d_next       = c_reg;
        d_next.d2    = {1'b0, c_reg.dxsq} + {1'b0, c_reg.dysq};
        d_next.rdiff = {1'b0, c_reg.r0sq} - {1'b0, c_reg.r1sq};
    end

    // intersect test and the signed chord numerator
    always_comb
    begin
        e_next     = d_reg;
        e_next.ok  = !d_reg.far && !d_reg.d2[64] && (d_reg.d2 != '0)
                     && (d_reg.d2[63:0] <= d_reg.ssq)
                     && (d_reg.d2[63:0] >= {2'b00, d_reg.dfsq});
        e_next.num = {2'b00, d_reg.d2} + 67'($signed(d_reg.rdiff));
    end

    cpi_sqrt u_sqrt_d
    (
        .clk  (clk),
        .en   (adv),
        .v    (e_reg.d2[63:0]),
        .root (root1)
    );

    assign neg_num = -sq1_line[SQRT_STEPS-1].num;

    always_comb
    begin
        f_next      = sq1_line[SQRT_STEPS-1];
        f_next.d    = root1;
        f_next.nneg = f_next.num[66];
        f_next.nmag = f_next.nneg ? neg_num[63:0] : f_next.num[63:0];
    end

    // quotient overflow means |a| is far beyond r0: saturate later
    always_comb
    begin
        g_next     = f_reg;
        g_next.ovf = {1'b0, f_reg.nmag[63:32]} >= {f_reg.d, 1'b0};
    end

    cpi_div u_div_a
    (
        .clk (clk),
        .en  (adv),
        .n   (g_reg.nmag),
        .dv  ({1'b0, g_reg.d, 1'b0}),
        .q   (q_a)
    );

    always_comb
    begin
        h_next      = dv1_line[DIV_STEPS-1];
        h_next.amag = (h_next.ovf || (q_a > {1'b0, h_next.r0})) ? h_next.r0 : q_a[30:0];
    end

    always_comb
    begin
        i_next      = h_reg;
        i_next.amsq = h_reg.amag * h_reg.amag;
    end

    always_comb
    begin
        j_next     = i_reg;
        j_next.hsq = i_reg.r0sq - i_reg.amsq;
    end

    cpi_sqrt u_sqrt_h
    (
        .clk  (clk),
        .en   (adv),
        .v    ({2'b00, j_reg.hsq}),
        .root (root2)
    );

    // products for the foot and the perpendicular offset
    always_comb
    begin
        k_next     = sq2_line[SQRT_STEPS-1];
        k_next.h   = root2[30:0];
        k_next.pax = k_next.adx * k_next.amag;
        k_next.pay = k_next.ady * k_next.amag;
        k_next.phx = k_next.adx * k_next.h;
        k_next.phy = k_next.ady * k_next.h;
    end

    cpi_div u_div_ax
    (
        .clk (clk),
        .en  (adv),
        .n   (k_reg.pax),
        .dv  ({2'b00, k_reg.d}),
        .q   (q_ax)
    );

    cpi_div u_div_ay
    (
        .clk (clk),
        .en  (adv),
        .n   (k_reg.pay),
        .dv  ({2'b00, k_reg.d}),
        .q   (q_ay)
    );

    cpi_div u_div_hx
    (
        .clk (clk),
        .en  (adv),
        .n   (k_reg.phx),
        .dv  ({2'b00, k_reg.d}),
        .q   (q_hx)
    );

    cpi_div u_div_hy
    (
        .clk (clk),
        .en  (adv),
        .n   (k_reg.phy),
        .dv  ({2'b00, k_reg.d}),
        .q   (q_hy)
    );

    // apply signs: foot p = c0 + (dx,dy)*a/d, offset o = (-dy*h/d, dx*h/d)
    always_comb
    begin
        m_next    = dv2_line[DIV_STEPS-1];
        m_next.px = 36'($signed(m_next.c0x))
                    + (((m_next.dx[32] ^ m_next.nneg) ? 36'(-{4'b0, q_ax}) : {4'b0, q_ax}));
        m_next.py = 36'($signed(m_next.c0y))
                    + (((m_next.dy[32] ^ m_next.nneg) ? 36'(-{4'b0, q_ay}) : {4'b0, q_ay}));
        m_next.ox = m_next.dy[32] ? {4'b0, q_hy} : 36'(-{4'b0, q_hy});
        m_next.oy = m_next.dx[32] ? 36'(-{4'b0, q_hx}) : {4'b0, q_hx};
    end

    always_comb
    begin
        n_next    = m_reg;
        n_next.fx = m_reg.px + m_reg.ox;
        n_next.fy = m_reg.py + m_reg.oy;
        n_next.sx = m_reg.px - m_reg.ox;
        n_next.sy = m_reg.py - m_reg.oy;
    end

    // saturate, drop the points of a pair that does not meet
    always_comb
    begin
        found_next = n_reg.ok;
        if (n_reg.ok)
            data_next = {sat32(n_reg.sy), sat32(n_reg.sx), sat32(n_reg.fy), sat32(n_reg.fx)};
        else
            data_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= {valid_reg[PIPE_DEPTH-3:0], s_tvalid};
            out_valid_reg <= valid_reg[PIPE_DEPTH-2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
            e_reg <= e_next;
            sq1_line[0] <= e_reg;
            for (int k = 1; k < SQRT_STEPS; k++)
                sq1_line[k] <= sq1_line[k-1];
            f_reg <= f_next;
            g_reg <= g_next;
            dv1_line[0] <= g_reg;
            for (int k = 1; k < DIV_STEPS; k++)
                dv1_line[k] <= dv1_line[k-1];
            h_reg <= h_next;
            i_reg <= i_next;
            j_reg <= j_next;
            sq2_line[0] <= j_reg;
            for (int k = 1; k < SQRT_STEPS; k++)
                sq2_line[k] <= sq2_line[k-1];
            k_reg <= k_next;
            dv2_line[0] <= k_reg;
            for (int k = 1; k < DIV_STEPS; k++)
                dv2_line[k] <= dv2_line[k-1];
            m_reg     <= m_next;
            n_reg     <= n_next;
            data_reg  <= data_next;
            found_reg <= found_next;
        end
    end

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("points not cleared for a pair that does not meet");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("accepted request did not enter the pipe");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg))
        else $error("pipe moved during a stall");

    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(found_reg) && $stable(data_reg))
        else $error("held result changed");
`endif

endmodule
